### rtl/vqdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtqueue descriptor manager package
// Beat types, status codes, descriptor flags and sequencer states.
// ----------------------------------------------------------------------------
package vqdm_pkg;

	localparam int         QUEUE_DEPTH = 256;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_REFUSED  = 2'd1;
	localparam logic [1:0] STAT_IGNORED  = 2'd2;
	localparam logic [1:0] STAT_BAD_HEAD = 2'd3;

	localparam logic       FUNC_SUBMIT   = 1'b0;
	localparam logic       FUNC_COMPLETE = 1'b1;

	localparam int         FL_NEXT_BIT  = 0;
	localparam int         FL_WRITE_BIT = 1;
	localparam logic [15:0] LINK_END    = 16'hFFFF;

	typedef struct packed {
		logic        func;
		logic        piece_first;
		logic        piece_last;
		logic [8:0]  chain_pieces;
		logic [63:0] buf_addr;
		logic [31:0] buf_len;
		logic        buf_device_writes;
		logic [31:0] cookie_tag;
		logic [15:0] used_head;
		logic [31:0] used_len;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  desc_index;
		logic [7:0]  chain_head;
		logic [7:0]  avail_slot;
		logic [15:0] avail_index;
		logic [31:0] done_len;
		logic [31:0] done_cookie;
		logic [8:0]  free_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SUB_JUDGE,
		S_SUB_POP,
		S_CPL_CHK,
		S_CPL_WALK,
		S_DONE
	} state_t;

endpackage

### rtl/vqdm_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module vqdm_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vqdm_pkg::rsp_t push_data,
	output logic          room,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output vqdm_pkg::rsp_t rsp
);
	import vqdm_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign room      = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (room && push) begin
			data_q <= push_data;
		end
	end

endmodule

### rtl/virtqueue_descriptor_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtqueue descriptor manager
// Keeps a split virtqueue descriptor table on a free list, fills chains from
// submitted pieces and returns completed chains to the free list.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Beat
//  req     | in        | req_valid/req_stall  | one piece or one used entry
//  rsp     | out       | rsp_valid/rsp_stall  | one result per request
//  cfg     | in        | cfg_we               | queue_size
//
// A submitted piece passes the judge, pop and done states; a refused or
// ignored piece judge and done; a bad used head check and done; a completion
// check, walk and done, the walk reading one descriptor a cycle from the link
// memory. After reset and after every queue_size write a clearing pass
// rebuilds the free list, one descriptor per cycle, for the effective queue
// size. A result waits in the output register while the next request is
// accepted; a stalled result holds the sequencer at its end.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [8:0]     cfg_wdata,
	input  logic           req_valid,
	output logic           req_stall,
	input  vqdm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vqdm_pkg::rsp_t rsp
);
	import vqdm_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

	function automatic logic [8:0] eff_size(input logic [8:0] v);
		int c;
		logic [8:0] p;
		c = int'(v);
		if (c > QUEUE_DEPTH) c = QUEUE_DEPTH;
		p = 9'd2;
		for (int k = 2; k <= 8; k++) begin
			if ((1 << k) <= c) p = 9'(1 << k);
		end
		return p;
	endfunction

	logic [63:0] addr_mem   [QUEUE_DEPTH];
	logic [31:0] len_mem    [QUEUE_DEPTH];
	logic [31:0] cookie_mem [QUEUE_DEPTH];
	logic [1:0]  flags_mem  [QUEUE_DEPTH];
	logic [15:0] link_mem   [QUEUE_DEPTH];

	state_t state_q, state_nxt;
	req_t   item_q;
	logic [8:0]    eff_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] free_head_q, cursor_q, start_q, walk_q;
	logic [8:0]    free_total_q, left_q, taken_q, cnt_q;
	logic [15:0]   avail_q;
	logic          open_q, refused_q;
	logic [1:0]    stat_q;
	logic [AW-1:0] dix_q, head_q;
	logic [7:0]    slot_q;
	logic [31:0]   dlen_q, dcookie_q;
	logic [1:0]    flags_rd_q;
	logic [15:0]   link_rd_q;
	logic [31:0]   cookie_rd_q;

	logic          accept, take, last_eff, walk_go;
	logic [AW-1:0] rd_addr, start_new;
	logic          link_we, flags_we, data_we, cookie_we, rd_en, cookie_rd_en;
	logic [AW-1:0] link_wa, flags_wa;
	logic [15:0]   link_wd;
	logic [1:0]    flags_wd;
	logic [9:0]    eff10, clr_inc, splice_sum, walk_sum;
	logic [15:0]   mask16, uh_ext;
	logic          room, push;
	rsp_t          res;

	assign eff10      = 10'(eff_q);
	assign mask16     = 16'(eff_q) - 16'd1;
	assign clr_inc    = 10'(clr_q) + 10'd1;
	assign splice_sum = 10'(free_total_q) + 10'(taken_q);
	assign walk_sum   = 10'(free_total_q) + 10'(cnt_q);
	assign uh_ext     = item_q.used_head;
	assign accept     = req_valid && !req_stall;
	assign start_new  = (taken_q == 9'd0) ? free_head_q : start_q;
	assign last_eff   = item_q.piece_last || (left_q == 9'd1);
	assign walk_go    = flags_rd_q[FL_NEXT_BIT] && (cnt_q < eff_q)
		&& (link_rd_q < 16'(eff_q));

	always_comb begin
		if (item_q.piece_first) begin
			take = !((item_q.chain_pieces == 9'd0) || (item_q.chain_pieces > free_total_q));
		end else begin
			take = open_q && !refused_q && (left_q != 9'd0) && (free_total_q != 9'd0);
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_inc == eff10) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = (req.func == FUNC_SUBMIT) ? S_SUB_JUDGE : S_CPL_CHK;
				end
			end
			S_SUB_JUDGE: state_nxt = take ? S_SUB_POP : S_DONE;
			S_SUB_POP:   state_nxt = S_DONE;
			S_CPL_CHK:   state_nxt = (uh_ext >= 16'(eff_q)) ? S_DONE : S_CPL_WALK;
			S_CPL_WALK: begin
				if (!walk_go) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (room) state_nxt = S_IDLE;
			end
			default: state_nxt = S_CLEAR;
		endcase
		if (cfg_we) state_nxt = S_CLEAR;
	end

	always_comb begin
		req_stall    = (state_q != S_IDLE);
		push         = (state_q == S_DONE);
		link_we      = 1'b0;
		link_wa      = cursor_q;
		link_wd      = 16'(free_head_q);
		flags_we     = 1'b0;
		flags_wa     = walk_q;
		flags_wd     = 2'b00;
		data_we      = 1'b0;
		cookie_we    = 1'b0;
		rd_en        = 1'b0;
		cookie_rd_en = 1'b0;
		rd_addr      = free_head_q;
		case (state_q)
			S_CLEAR: begin
				link_we  = 1'b1;
				link_wa  = clr_q;
				link_wd  = (clr_inc < eff10) ? 16'(clr_inc) : LINK_END;
				flags_we = 1'b1;
				flags_wa = clr_q;
			end
			S_IDLE: begin
				link_we = accept && (req.func == FUNC_SUBMIT) && req.piece_first
					&& open_q && (taken_q != 9'd0);
			end
			S_SUB_JUDGE: rd_en = take;
			S_SUB_POP: begin
				link_we   = (taken_q != 9'd0);
				link_wd   = 16'(free_head_q);
				flags_we  = 1'b1;
				flags_wa  = free_head_q;
				flags_wd  = {item_q.buf_device_writes, !last_eff};
				data_we   = 1'b1;
				cookie_we = last_eff;
			end
			S_CPL_CHK: begin
				rd_addr      = uh_ext[AW-1:0];
				rd_en        = (uh_ext < 16'(eff_q));
				cookie_rd_en = rd_en;
			end
			S_CPL_WALK: begin
				rd_addr  = link_rd_q[AW-1:0];
				rd_en    = walk_go;
				link_we  = !walk_go;
				link_wa  = walk_q;
				flags_we = !walk_go;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		if (flags_we) flags_mem[flags_wa] <= flags_wd;
		if (data_we) begin
			addr_mem[free_head_q] <= item_q.buf_addr;
			len_mem[free_head_q]  <= item_q.buf_len;
		end
		if (cookie_we) cookie_mem[start_new] <= item_q.cookie_tag;
		if (rd_en) begin
			link_rd_q  <= link_mem[rd_addr];
			flags_rd_q <= flags_mem[rd_addr];
		end
		if (cookie_rd_en) cookie_rd_q <= cookie_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			eff_q        <= eff_size(9'd256);
			clr_q        <= '0;
			free_head_q  <= '0;
			free_total_q <= eff_size(9'd256);
			avail_q      <= '0;
			cursor_q     <= '0;
			start_q      <= '0;
			open_q       <= 1'b0;
			refused_q    <= 1'b0;
			left_q       <= '0;
			taken_q      <= '0;
		end else if (cfg_we) begin
			state_q      <= S_CLEAR;
			eff_q        <= eff_size(cfg_wdata);
			clr_q        <= '0;
			free_head_q  <= '0;
			free_total_q <= eff_size(cfg_wdata);
			avail_q      <= '0;
			cursor_q     <= '0;
			start_q      <= '0;
			open_q       <= 1'b0;
			refused_q    <= 1'b0;
			left_q       <= '0;
			taken_q      <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				S_CLEAR: clr_q <= clr_inc[AW-1:0];
				S_IDLE: begin
					if (accept && (req.func == FUNC_SUBMIT) && req.piece_first) begin
						if (open_q && (taken_q != 9'd0)) begin
							free_head_q  <= start_q;
							free_total_q <= (splice_sum > eff10) ? eff_q : splice_sum[8:0];
						end
						open_q  <= 1'b0;
						taken_q <= '0;
						left_q  <= '0;
					end
				end
				S_SUB_JUDGE: begin
					if (item_q.piece_first) begin
						refused_q <= !take;
						open_q    <= take;
						left_q    <= take ? item_q.chain_pieces : 9'd0;
					end
				end
				S_SUB_POP: begin
					free_head_q <= (link_rd_q < 16'(eff_q)) ? link_rd_q[AW-1:0] : '0;
					if (free_total_q != 9'd0) free_total_q <= free_total_q - 9'd1;
					start_q  <= start_new;
					cursor_q <= free_head_q;
					if (last_eff) begin
						avail_q <= avail_q + 16'd1;
						open_q  <= 1'b0;
						left_q  <= '0;
						taken_q <= '0;
					end else begin
						left_q  <= left_q - 9'd1;
						taken_q <= taken_q + 9'd1;
					end
				end
				S_CPL_WALK: begin
					if (!walk_go) begin
						free_head_q  <= item_q.used_head[AW-1:0];
						free_total_q <= (walk_sum > eff10) ? eff_q : walk_sum[8:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q    <= req;
				stat_q    <= STAT_OK;
				dix_q     <= '0;
				head_q    <= '0;
				slot_q    <= '0;
				dlen_q    <= '0;
				dcookie_q <= '0;
			end
			S_SUB_JUDGE: begin
				if (!take) stat_q <= item_q.piece_first ? STAT_REFUSED : STAT_IGNORED;
			end
			S_SUB_POP: begin
				dix_q  <= free_head_q;
				head_q <= start_new;
				if (last_eff) slot_q <= 8'(avail_q & mask16);
			end
			S_CPL_CHK: begin
				walk_q <= uh_ext[AW-1:0];
				cnt_q  <= 9'd1;
				if (uh_ext >= 16'(eff_q)) begin
					stat_q <= STAT_BAD_HEAD;
				end else begin
					head_q <= uh_ext[AW-1:0];
					dlen_q <= item_q.used_len;
				end
			end
			S_CPL_WALK: begin
				if (walk_go) begin
					walk_q <= link_rd_q[AW-1:0];
					cnt_q  <= cnt_q + 9'd1;
				end else begin
					dcookie_q <= cookie_rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.status      = stat_q;
		res.desc_index  = 8'(16'(dix_q));
		res.chain_head  = 8'(16'(head_q));
		res.avail_slot  = slot_q;
		res.avail_index = avail_q;
		res.done_len    = dlen_q;
		res.done_cookie = dcookie_q;
		res.free_count  = free_total_q;
	end

	vqdm_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### rtl/vqdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtqueue descriptor manager port checker
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module vqdm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input vqdm_pkg::rsp_t rsp
);
	import vqdm_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result beat changed or dropped.");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Request beat accepted while the previous one is in work.");

	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STAT_REFUSED || rsp.status == STAT_IGNORED)
		|-> rsp.desc_index == 8'd0 && rsp.chain_head == 8'd0 && rsp.avail_slot == 8'd0)
		else $error("Refused or ignored piece reports a descriptor.");

	a_bad_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_BAD_HEAD
		|-> rsp.done_len == 32'd0 && rsp.done_cookie == 32'd0)
		else $error("Bad used head returns a length or cookie.");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.free_count <= 9'd256)
		else $error("Free count above the largest queue size.");

endmodule

bind virtqueue_descriptor_manager_top vqdm_checker u_vqdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### dv/virtqueue_descriptor_manager_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtqueue descriptor manager checker
// Watches the request, response and configuration ports, keeps its own copy of
// the descriptor table and free list, and compares every response beat.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [8:0]     cfg_wdata,
	input  logic           req_valid,
	input  logic           req_stall,
	input  vqdm_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  vqdm_pkg::rsp_t rsp,
	output int             errors,
	output int             pending,
	output int             results_seen
);
	import vqdm_pkg::*;

	localparam int DEPTH = 256;

	logic [63:0] tbl_addr [DEPTH];
	logic [31:0] tbl_len [DEPTH];
	logic [1:0]  tbl_flags [DEPTH];
	logic [15:0] tbl_link [DEPTH];
	logic [31:0] tbl_cookie [DEPTH];
	int          qsize_reg;
	int          free_hd;
	int          free_cnt;
	logic [15:0] avail_ctr;
	logic [15:0] used_ctr;
	int          cursor;
	int          start_desc;
	bit          refused;
	bit          open_chain;
	int          left_cnt;
	int          taken_cnt;
	rsp_t        expected_rsp [$];

	function automatic int active_size();
		int v;
		int p;
		v = qsize_reg;
		p = 2;
		if (v > DEPTH) v = DEPTH;
		while (p * 2 <= v) p = p * 2;
		return p;
	endfunction

	function automatic void rebuild_free_list();
		int n;
		n = active_size();
		for (int i = 0; i < DEPTH; i++) begin
			tbl_link[i] = (i + 1 < n) ? 16'(i + 1) : LINK_END;
			tbl_flags[i] = 2'b00;
		end
		free_hd = 0;
		free_cnt = n;
		avail_ctr = '0;
		used_ctr = '0;
		cursor = 0;
		start_desc = 0;
		refused = 0;
		open_chain = 0;
		left_cnt = 0;
		taken_cnt = 0;
	endfunction

	function automatic rsp_t predict_descriptor_result(req_t r);
		rsp_t o;
		int n;
		bit lst;
		bit take;
		int d;
		int j;
		int cnt;
		n = active_size();
		o = '0;
		take = 0;
		lst = r.piece_last;
		if (r.func == FUNC_SUBMIT) begin
			if (r.piece_first) begin
				if (open_chain && taken_cnt > 0) begin
					tbl_link[cursor & (n - 1)] = 16'(free_hd);
					free_hd = start_desc & (n - 1);
					free_cnt += taken_cnt;
					if (free_cnt > n) free_cnt = n;
				end
				open_chain = 0;
				taken_cnt = 0;
				left_cnt = 0;
				if (r.chain_pieces == 0 || r.chain_pieces > free_cnt) begin
					refused = 1;
					o.status = STAT_REFUSED;
				end else begin
					refused = 0;
					open_chain = 1;
					left_cnt = r.chain_pieces;
					take = 1;
				end
			end else if (open_chain && !refused && left_cnt > 0 && free_cnt > 0) begin
				take = 1;
			end else begin
				o.status = STAT_IGNORED;
			end
			if (take) begin
				d = free_hd & (n - 1);
				free_hd = (tbl_link[d] < n) ? tbl_link[d] : 0;
				if (free_cnt > 0) free_cnt--;
				if (taken_cnt == 0) start_desc = d;
				else tbl_link[cursor & (n - 1)] = 16'(d);
				cursor = d;
				taken_cnt++;
				left_cnt--;
				if (left_cnt == 0) lst = 1;
				tbl_addr[d] = r.buf_addr;
				tbl_len[d] = r.buf_len;
				tbl_flags[d] = {r.buf_device_writes, !lst};
				o.desc_index = 8'(d);
				o.chain_head = 8'(start_desc);
				if (lst) begin
					tbl_cookie[start_desc] = r.cookie_tag;
					o.avail_slot = 8'(avail_ctr & 16'(n - 1));
					avail_ctr = avail_ctr + 16'd1;
					open_chain = 0;
					left_cnt = 0;
					taken_cnt = 0;
				end
			end
		end else begin
			used_ctr = used_ctr + 16'd1;
			if (r.used_head >= n) begin
				o.status = STAT_BAD_HEAD;
			end else begin
				j = r.used_head;
				cnt = 1;
				o.done_len = r.used_len;
				o.done_cookie = tbl_cookie[j];
				while (tbl_flags[j][FL_NEXT_BIT] && cnt < n) begin
					if (tbl_link[j] >= n) break;
					j = tbl_link[j];
					cnt++;
				end
				tbl_link[j] = 16'(free_hd);
				tbl_flags[j] = 2'b00;
				free_hd = r.used_head;
				free_cnt += cnt;
				if (free_cnt > n) free_cnt = n;
				o.chain_head = 8'(r.used_head);
			end
		end
		o.avail_index = avail_ctr;
		o.free_count = 9'(free_cnt);
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: response %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			qsize_reg = 256;
			rebuild_free_list();
			expected_rsp.delete();
			errors = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsp.push_back(predict_descriptor_result(req));
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (expected_rsp.size() == 0) begin
					report_mismatch("beat with nothing expected", 64'd0, 64'd0);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.status !== e.status)
						report_mismatch("status", rsp.status, e.status);
					if (rsp.desc_index !== e.desc_index)
						report_mismatch("desc_index", rsp.desc_index, e.desc_index);
					if (rsp.chain_head !== e.chain_head)
						report_mismatch("chain_head", rsp.chain_head, e.chain_head);
					if (rsp.avail_slot !== e.avail_slot)
						report_mismatch("avail_slot", rsp.avail_slot, e.avail_slot);
					if (rsp.avail_index !== e.avail_index)
						report_mismatch("avail_index", rsp.avail_index, e.avail_index);
					if (rsp.done_len !== e.done_len)
						report_mismatch("done_len", rsp.done_len, e.done_len);
					if (rsp.done_cookie !== e.done_cookie)
						report_mismatch("done_cookie", rsp.done_cookie, e.done_cookie);
					if (rsp.free_count !== e.free_count)
						report_mismatch("free_count", rsp.free_count, e.free_count);
				end
			end
			if (cfg_we) begin
				qsize_reg = cfg_wdata;
				rebuild_free_list();
			end
			pending = expected_rsp.size();
		end
	end

endmodule

### dv/virtqueue_descriptor_manager_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtqueue descriptor manager testbench
// Drives directed and random descriptor chains and completions through several
// queue sizes and flow-control mixes; a checker module predicts every beat.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_top_test;
	import vqdm_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [8:0] cfg_wdata = '0;
	logic req_valid = 0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	rsp_t rsp;
	int errors;
	int pending;
	int results_seen;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;
	int idle_cycles = 0;
	int beats_sent = 0;
	int sizes_tried = 0;
	int cur_size = 256;
	int outstanding_heads [$];
	bit [255:0] cookie_written;

	always #5 clk = ~clk;

	virtqueue_descriptor_manager_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	virtqueue_descriptor_manager_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	always @(negedge clk) begin
		if (hold_off) rsp_stall <= 1;
		else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Run stalled with %0d beats outstanding.", pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_beat(req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		req <= r;
		req_valid <= 1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		req_valid <= 0;
		beats_sent++;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_queue_size(logic [8:0] v);
		int p;
		drain();
		cfg_wdata <= v;
		cfg_we <= 1;
		@(negedge clk);
		cfg_we <= 0;
		p = 2;
		while (p * 2 <= ((v > 256) ? 256 : v)) p = p * 2;
		cur_size = p;
		outstanding_heads.delete();
		cookie_written = '0;
		sizes_tried++;
	endtask

	function automatic req_t random_piece();
		req_t r;
		r = '0;
		r.func = FUNC_SUBMIT;
		r.buf_addr = {$urandom, $urandom};
		r.buf_len = $urandom;
		r.buf_device_writes = 1'($urandom_range(1));
		r.cookie_tag = $urandom;
		r.used_len = $urandom;
		r.used_head = 16'($urandom);
		r.chain_pieces = 9'($urandom);
		return r;
	endfunction

	task automatic submit_chain(int pieces, int declared);
		req_t r;
		for (int i = 0; i < pieces; i++) begin
			r = random_piece();
			r.piece_first = (i == 0);
			r.piece_last = (i == pieces - 1);
			r.chain_pieces = 9'(declared);
			send_beat(r);
		end
	endtask

	// Heads are tracked after a drain so that the prediction's free list is settled.
	task automatic complete_head(int h);
		req_t r;
		r = random_piece();
		r.func = FUNC_COMPLETE;
		r.used_head = 16'(h);
		send_beat(r);
	endtask

	task automatic good_chain(int pieces);
		int head;
		drain();
		head = i_checker_free_head();
		submit_chain(pieces, pieces);
		cookie_written[head] = 1;
		outstanding_heads.push_back(head);
	endtask

	function automatic int i_checker_free_head();
		return i_checker.free_hd & (cur_size - 1);
	endfunction

	task automatic random_traffic(int count);
		int k;
		int len;
		req_t r;
		int idx;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 45 && pending == 0) begin
				len = $urandom_range(1, (cur_size > 4) ? 4 : cur_size);
				if (len <= i_checker.free_cnt) good_chain(len);
				else submit_chain(1, len);
			end else if (k < 70 && outstanding_heads.size() > 0) begin
				idx = $urandom_range(outstanding_heads.size() - 1);
				complete_head(outstanding_heads[idx]);
				outstanding_heads.delete(idx);
			end else if (k < 80) begin
				complete_head($urandom_range(cur_size, 65535));
			end else begin
				r = random_piece();
				r.piece_first = 1'($urandom_range(1));
				r.piece_last = 1'($urandom_range(1));
				if ($urandom_range(1)) r.chain_pieces = 9'($urandom_range(0, 3));
				if (r.piece_first) begin
					r.chain_pieces = (r.chain_pieces == 0) ? 9'd0 : 9'(cur_size + 1);
				end
				send_beat(r);
			end
		end
	endtask

	initial begin
		req_t r;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		cookie_written = '0;
		drain();

		good_chain(1);
		good_chain(3);
		submit_chain(1, 0);
		submit_chain(2, 300);
		r = random_piece();
		r.piece_first = 0;
		r.buf_addr = '1;
		r.buf_len = '1;
		send_beat(r);
		submit_chain(2, 5);
		submit_chain(3, 2);
		drain();
		complete_head(256);
		complete_head(16'hFFFF);
		r = random_piece();
		r.buf_addr = '0;
		r.buf_len = '0;
		r.cookie_tag = '1;
		r.piece_first = 1;
		r.piece_last = 1;
		r.chain_pieces = 9'd1;
		send_beat(r);
		drain();
		outstanding_heads.push_back(i_checker.start_desc);
		while (outstanding_heads.size() > 0) begin
			complete_head(outstanding_heads.pop_front());
		end

		write_queue_size(9'd2);
		good_chain(2);
		submit_chain(1, 1);
		complete_head(outstanding_heads.pop_front());
		write_queue_size(9'd0);
		random_traffic(40);

		write_queue_size(9'd511);
		random_traffic(100);

		send_idle_pct = 63;
		write_queue_size(9'd5);
		random_traffic(100);

		send_idle_pct = 0;
		recv_stall_pct = 63;
		write_queue_size(9'd16);
		random_traffic(100);

		send_idle_pct = 38;
		recv_stall_pct = 38;
		write_queue_size(9'd100);
		random_traffic(100);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			begin
				for (int i = 0; i < 20; i++) complete_head(16'hFFFF);
			end
		join
		drain();
		write_queue_size(9'd256);
		random_traffic(120);

		drain();
		$display("Sent %0d beats over %0d queue sizes and checked %0d results,",
			beats_sent, sizes_tried, results_seen);
		$display("including refusals, stray pieces, early ends and bad used heads.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
